// ===== rtl/core/ecal_pkg.sv =====
// ----------------------------------------------------------------------------
// ecal_pkg
// Shared types, codes and constants of the elapsed-seconds to calendar date
// converter.
// ----------------------------------------------------------------------------
package ecal_pkg;

  localparam int unsigned PADDR_W  = 3;
  localparam int unsigned PDATA_W  = 32;

  // Register index, taken from the word address
  localparam logic CFG_START_YEAR = 1'b0;

  localparam logic [11:0] START_YEAR_RST = 12'd1970;

  // Division by 86400, 3600 and 60: drop the power-of-two factor, then
  // multiply by the rounded-up reciprocal of the odd part and shift
  localparam logic [25:0] DAY_RECIP  = 26'd50903317;  // 2^35 / 675
  localparam logic [9:0]  DAY_ODD    = 10'd675;       // 86400 >> 7
  localparam logic [13:0] HOUR_RECIP = 14'd9321;      // 2^21 / 225
  localparam logic [7:0]  HOUR_ODD   = 8'd225;        // 3600 >> 4
  localparam logic [10:0] MIN_RECIP  = 11'd1093;      // 2^14 / 15
  localparam logic [3:0]  MIN_ODD    = 4'd15;         // 60 >> 2

  localparam logic [8:0] DAYS_COMMON_YEAR = 9'd365;
  localparam logic [3:0] MONTH_JAN        = 4'd1;
  localparam logic [3:0] MONTH_FEB        = 4'd2;
  localparam logic [3:0] MONTH_DEC        = 4'd12;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV_DAY,
    ST_DAY_END,
    ST_DIV_HOUR,
    ST_HOUR_END,
    ST_DIV_MIN,
    ST_MIN_END,
    ST_YEAR,
    ST_MONTH,
    ST_WRITE
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_DIV,
    OP_DAY_END,
    OP_HOUR_END,
    OP_MIN_END,
    OP_YEAR,
    OP_MONTH,
    OP_OUT
  } op_t;

  typedef enum logic [1:0] {
    DV_DAY,
    DV_HOUR,
    DV_MIN
  } div_sel_t;

  typedef struct packed {
    op_t      op;
    div_sel_t sel;
  } cmd_t;

  typedef struct packed {
    logic year_done;
    logic month_done;
  } sts_t;

  function automatic logic is_leap(input logic [11:0] year);
    return (year[1:0] == 2'b00);
  endfunction

  function automatic logic [4:0] month_days(input logic [3:0] mon, input logic leap);
    logic [4:0] len;
    case (mon)
      MONTH_FEB: len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// ===== rtl/core/ecal_dpath.sv =====
// ----------------------------------------------------------------------------
// ecal_dpath
// Shared reciprocal multiplier for the time of day steps, the year and month
// walkers, and the output register.
// ----------------------------------------------------------------------------
module ecal_dpath
  import ecal_pkg::*;
(
  input  logic        clk,
  input  cmd_t        cmd,
  input  logic [31:0] in_elapsed_seconds,
  input  logic [11:0] start_year,
  output sts_t        sts,
  output logic [5:0]  out_second_of_minute,
  output logic [5:0]  out_minute_of_hour,
  output logic [4:0]  out_hour_of_day,
  output logic [4:0]  out_day_of_month,
  output logic [3:0]  out_month_of_year,
  output logic [11:0] out_calendar_year
);

  logic [31:0] secs_r, secs_nxt;
  logic [50:0] prod_r, prod_nxt;
  logic [16:0] rem_r, rem_nxt;
  logic [15:0] day_r, day_nxt;
  logic [11:0] year_r, year_nxt;
  logic [3:0]  mon_r, mon_nxt;
  logic [4:0]  hour_r, hour_nxt;
  logic [5:0]  min_r, min_nxt;
  logic [5:0]  sec_r, sec_nxt;

  logic [5:0]  osec_r, osec_nxt;
  logic [5:0]  omin_r, omin_nxt;
  logic [4:0]  ohour_r, ohour_nxt;
  logic [4:0]  oday_r, oday_nxt;
  logic [3:0]  omon_r, omon_nxt;
  logic [11:0] oyear_r, oyear_nxt;

  logic [24:0] mul_a;
  logic [25:0] mul_b;
  logic [15:0] day_q;
  logic [4:0]  hour_q;
  logic [5:0]  min_q;
  logic [24:0] day_left;
  logic [12:0] hour_left;
  logic [9:0]  min_left;
  logic        leap;
  logic [8:0]  ylen;
  logic [4:0]  mlen;

  always_comb begin
    case (cmd.sel)
      DV_DAY: begin
        mul_a = secs_r[31:7];
        mul_b = DAY_RECIP;
      end
      DV_HOUR: begin
        mul_a = {12'b0, rem_r[16:4]};
        mul_b = {12'b0, HOUR_RECIP};
      end
      DV_MIN: begin
        mul_a = {15'b0, rem_r[11:2]};
        mul_b = {15'b0, MIN_RECIP};
      end
      default: begin
        mul_a = secs_r[31:7];
        mul_b = DAY_RECIP;
      end
    endcase
  end

  assign day_q     = prod_r[50:35];
  assign hour_q    = prod_r[25:21];
  assign min_q     = prod_r[19:14];
  assign day_left  = secs_r[31:7] - ({9'b0, day_q} * {15'b0, DAY_ODD});
  assign hour_left = rem_r[16:4] - ({8'b0, hour_q} * {5'b0, HOUR_ODD});
  assign min_left  = rem_r[11:2] - ({4'b0, min_q} * {6'b0, MIN_ODD});

  assign leap     = is_leap(year_r);
  assign ylen     = leap ? DAYS_COMMON_YEAR + 9'd1 : DAYS_COMMON_YEAR;
  assign mlen     = month_days(mon_r, leap);

  assign sts.year_done  = (day_r <= {7'b0, ylen});
  assign sts.month_done = (day_r <= {11'b0, mlen}) || (mon_r == MONTH_DEC);

  always_comb begin
    secs_nxt  = secs_r;
    prod_nxt  = prod_r;
    rem_nxt   = rem_r;
    day_nxt   = day_r;
    year_nxt  = year_r;
    mon_nxt   = mon_r;
    hour_nxt  = hour_r;
    min_nxt   = min_r;
    sec_nxt   = sec_r;
    osec_nxt  = osec_r;
    omin_nxt  = omin_r;
    ohour_nxt = ohour_r;
    oday_nxt  = oday_r;
    omon_nxt  = omon_r;
    oyear_nxt = oyear_r;
    case (cmd.op)
      OP_LOAD: begin
        secs_nxt = in_elapsed_seconds;
      end
      OP_DIV: begin
        prod_nxt = mul_a * mul_b;
      end
      OP_DAY_END: begin
        day_nxt  = 16'(day_q + 16'd1);
        year_nxt = start_year;
        // put the low seven bits back under the odd-part remainder
        rem_nxt  = {day_left[9:0], secs_r[6:0]};
      end
      OP_HOUR_END: begin
        hour_nxt = hour_q;
        rem_nxt  = {5'b0, hour_left[7:0], rem_r[3:0]};
      end
      OP_MIN_END: begin
        min_nxt = min_q;
        sec_nxt = {min_left[3:0], rem_r[1:0]};
        mon_nxt = MONTH_JAN;
      end
      OP_YEAR: begin
        if (!sts.year_done) begin
          day_nxt  = 16'(day_r - {7'b0, ylen});
          year_nxt = 12'(year_r + 12'd1);
        end
      end
      OP_MONTH: begin
        if (!sts.month_done) begin
          day_nxt = 16'(day_r - {11'b0, mlen});
          mon_nxt = 4'(mon_r + 4'd1);
        end
      end
      OP_OUT: begin
        osec_nxt  = sec_r;
        omin_nxt  = min_r;
        ohour_nxt = hour_r;
        oday_nxt  = day_r[4:0];
        omon_nxt  = mon_r;
        oyear_nxt = year_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    secs_r  <= secs_nxt;
    prod_r  <= prod_nxt;
    rem_r   <= rem_nxt;
    day_r   <= day_nxt;
    year_r  <= year_nxt;
    mon_r   <= mon_nxt;
    hour_r  <= hour_nxt;
    min_r   <= min_nxt;
    sec_r   <= sec_nxt;
    osec_r  <= osec_nxt;
    omin_r  <= omin_nxt;
    ohour_r <= ohour_nxt;
    oday_r  <= oday_nxt;
    omon_r  <= omon_nxt;
    oyear_r <= oyear_nxt;
  end

  assign out_second_of_minute = osec_r;
  assign out_minute_of_hour   = omin_r;
  assign out_hour_of_day      = ohour_r;
  assign out_day_of_month     = oday_r;
  assign out_month_of_year    = omon_r;
  assign out_calendar_year    = oyear_r;

endmodule

// ===== rtl/core/ecal_ctrl.sv =====
// ----------------------------------------------------------------------------
// ecal_ctrl
// Sequencer: time of day steps, year walk, month walk, output handoff.
// ----------------------------------------------------------------------------
module ecal_ctrl
  import ecal_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t     state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd.op    = OP_NONE;
    cmd.sel   = DV_DAY;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = ST_DIV_DAY;
        end
      end
      ST_DIV_DAY: begin
        cmd.op    = OP_DIV;
        cmd.sel   = DV_DAY;
        state_nxt = ST_DAY_END;
      end
      ST_DAY_END: begin
        cmd.op    = OP_DAY_END;
        state_nxt = ST_DIV_HOUR;
      end
      ST_DIV_HOUR: begin
        cmd.op    = OP_DIV;
        cmd.sel   = DV_HOUR;
        state_nxt = ST_HOUR_END;
      end
      ST_HOUR_END: begin
        cmd.op    = OP_HOUR_END;
        state_nxt = ST_DIV_MIN;
      end
      ST_DIV_MIN: begin
        cmd.op    = OP_DIV;
        cmd.sel   = DV_MIN;
        state_nxt = ST_MIN_END;
      end
      ST_MIN_END: begin
        cmd.op    = OP_MIN_END;
        state_nxt = ST_YEAR;
      end
      ST_YEAR: begin
        cmd.op = OP_YEAR;
        if (sts.year_done) begin
          state_nxt = ST_MONTH;
        end
      end
      ST_MONTH: begin
        cmd.op = OP_MONTH;
        if (sts.month_done) begin
          state_nxt = ST_WRITE;
        end
      end
      ST_WRITE: begin
        // hold until the output register is free
        if (!out_valid_r || !out_stall) begin
          cmd.op    = OP_OUT;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = (cmd.op == OP_OUT) || (out_valid_r && out_stall);
  assign in_stall      = (state_r != ST_IDLE);
  assign out_valid     = out_valid_r;

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == ST_DIV_DAY))
    else $error("accepted transfer did not start the day division");

  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_OUT) |=> out_valid)
    else $error("result loaded but not presented");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |-> (cmd.op != OP_OUT))
    else $error("stalled result overwritten");

  a_year_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_YEAR && !sts.year_done) |=> (state_r == ST_YEAR))
    else $error("year walk left before the day count fit");

  a_write_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WRITE && out_valid && out_stall) |=> (state_r == ST_WRITE))
    else $error("finished item left while the output register was busy");

endmodule

// ===== rtl/core/epoch_seconds_to_calendar_date_top.sv =====
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_date_top
// Converts a 32-bit count of seconds since January first of a programmable
// start year into time of day and calendar date.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_stall carries in_elapsed_seconds; a transfer
//   happens when in_valid is high and in_stall is low. The result channel
//   out_valid/out_stall carries second, minute, hour, day, month and year.
//   One item is converted at a time: in_stall is low only while idle.
//   Each item passes through six time of day steps in a shared reciprocal
//   multiplier, then the one-year-per-cycle walk over up to 136 years from
//   the start year and the one-month-per-cycle walk up to its month, and
//   then waits for the output register.
//   The output register holds a finished result while out_stall is high;
//   the next item is accepted meanwhile and waits at its last step until
//   that register frees up.
//   start_year is written over the APB port at address 0; write it only
//   while idle, the block does not enforce this. Synchronous reset clears
//   both channels' control state and sets start_year to 1970.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar_date_top
  import ecal_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [31:0]        in_elapsed_seconds,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [5:0]         out_second_of_minute,
  output logic [5:0]         out_minute_of_hour,
  output logic [4:0]         out_hour_of_day,
  output logic [4:0]         out_day_of_month,
  output logic [3:0]         out_month_of_year,
  output logic [11:0]        out_calendar_year,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  logic [11:0] start_year_r, start_year_nxt;
  logic        cfg_wr;
  cmd_t        cmd;
  sts_t        sts;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    start_year_nxt = start_year_r;
    if (cfg_wr && (paddr[2] == CFG_START_YEAR)) begin
      start_year_nxt = pwdata[11:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_year_r <= START_YEAR_RST;
    end else begin
      start_year_r <= start_year_nxt;
    end
  end

  assign prdata = (paddr[2] == CFG_START_YEAR) ? {20'b0, start_year_r} : '0;

  ecal_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  ecal_dpath u_dpath (
    .clk                  (clk),
    .cmd                  (cmd),
    .in_elapsed_seconds   (in_elapsed_seconds),
    .start_year           (start_year_r),
    .sts                  (sts),
    .out_second_of_minute (out_second_of_minute),
    .out_minute_of_hour   (out_minute_of_hour),
    .out_hour_of_day      (out_hour_of_day),
    .out_day_of_month     (out_day_of_month),
    .out_month_of_year    (out_month_of_year),
    .out_calendar_year    (out_calendar_year)
  );

endmodule
